// File: sv/u8vc_pkg.sv
// ----------------------------------------------------------------------------
// u8vc_pkg
// Types and codes shared by the UTF-8 validate and count unit and its checker.
// ----------------------------------------------------------------------------
package u8vc_pkg;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_LEAD  = 2'd1,
      ERR_CONT  = 2'd2,
      ERR_TRUNC = 2'd3
   } err_kind_type;

   localparam int unsigned COUNT_OUT_W = 21;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] char_count;
      logic                   valid_res;
      err_kind_type           error_kind;
   } rsp_payload_type;

endpackage

// File: sv/utf8_validate_and_count_unit.sv
// ----------------------------------------------------------------------------
// utf8_validate_and_count_unit
// Relaxed UTF-8 checker and character counter, one byte per word.
// ----------------------------------------------------------------------------
// The unit takes one string byte per cycle. It updates a small
// sequence state (pending continuation bytes, count, first error) in the same
// cycle as the byte is taken. A word with last set produces one result, which
// is registered and shown in the next cycle, after which the state is back to
// reset for the next string. Words without last produce nothing. A new byte
// is taken every cycle unless a result waits in the output register while
// the result side stalls. The count saturates at MAX_CHARS; char_count shows
// its low 21 bits.
module utf8_validate_and_count_unit
   import u8vc_pkg::*;
#(
   parameter longint unsigned MAX_CHARS = 1048576
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int unsigned CNT_W = $clog2(MAX_CHARS + 64'd1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

   logic [1:0]       pending_ff, pending_in;
   logic [CNT_W-1:0] count_ff, count_in;
   err_kind_type     err_ff, err_in;
   logic             held_ff, held_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic             accept;
   logic [7:0]       b;
   logic [1:0]       pend_dec;
   logic             held_upd;
   err_kind_type     kind;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_payload.data_byte;

   // next sequence state for the byte on the input
   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      err_in     = err_ff;
      held_in    = held_ff;
      pend_dec   = pending_ff - 2'd1;
      held_upd   = held_ff | (b[7:6] != 2'b10);
      if (err_ff == ERR_NONE) begin
         if (pending_ff != 2'd0) begin
            pending_in = pend_dec;
            held_in    = held_upd;
            if (pend_dec == 2'd0) begin
               held_in = 1'b0;
               if (held_upd) begin
                  err_in = ERR_CONT;
               end else if (count_ff != CNT_MAX) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end else if (b[7] == 1'b0) begin
            if (count_ff != CNT_MAX) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (b[7:5] == 3'b110) begin
            pending_in = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            pending_in = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            pending_in = 2'd3;
         end else begin
            err_in = ERR_LEAD;
         end
      end
   end

   // result for a last byte: truncation wins over a held bad continuation
   always_comb begin
      kind = err_in;
      if (err_in == ERR_NONE && pending_in != 2'd0) begin
         kind = ERR_TRUNC;
      end
      count_wide                = {{COUNT_OUT_W{1'b0}}, count_in};
      rsp_payload_in.char_count = count_wide[COUNT_OUT_W-1:0];
      rsp_payload_in.valid_res  = (kind == ERR_NONE);
      rsp_payload_in.error_kind = kind;
      rsp_valid_in              = rsp_valid_ff & rsp_stall;
      if (accept && req_payload.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 2'd0;
         count_ff     <= '0;
         err_ff       <= ERR_NONE;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_payload.last) begin
               // drop the string state for the next string
               pending_ff <= 2'd0;
               count_ff   <= '0;
               err_ff     <= ERR_NONE;
               held_ff    <= 1'b0;
            end else begin
               pending_ff <= pending_in;
               count_ff   <= count_in;
               err_ff     <= err_in;
               held_ff    <= held_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: sv/u8vc_checker.sv
// ----------------------------------------------------------------------------
// u8vc_checker
// Port-level checks for the UTF-8 validate and count unit.
// ----------------------------------------------------------------------------
module u8vc_checker
   import u8vc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result word changed");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.last |=> rsp_valid)
      else $error("last byte gave no result");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && req_payload.last) && !(rsp_valid && rsp_stall)
      |=> !rsp_valid)
      else $error("result without a last byte");

   a_flag_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.valid_res == (rsp_payload.error_kind == ERR_NONE))
      else $error("valid_res disagrees with error_kind");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with a free output");

endmodule

bind utf8_validate_and_count_unit u8vc_checker u_u8vc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
